### src/snd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command codes and the hash helper for the 2-D simplex noise block.
// Used by snd_corner.sv and simplex_noise_2d.sv; no dependencies.

package snd_pkg;

  // command codes
  localparam logic [1:0] CMD_EVAL = 2'd0;
  localparam logic [1:0] CMD_PERM = 2'd1;
  localparam logic [1:0] CMD_GRAD = 2'd2;

  // table sizes
  localparam int unsigned PERM_ENTRIES = 512;
  localparam int unsigned PERM_AW      = $clog2(PERM_ENTRIES);
  localparam int unsigned GRAD_ENTRIES = 128;
  localparam int unsigned GRAD_AW      = $clog2(GRAD_ENTRIES);

  // pipeline depth from accept to output register
  localparam int unsigned PIPE_DEPTH = 17;
  // last stage that still carries load fields (gradient write stage)
  localparam int unsigned LOAD_DEPTH = 8;

  // skew and unskew constants, Q0.16
  localparam logic signed [16:0] F2_Q16 = 17'sd23986;
  localparam logic signed [15:0] G2_Q16 = 16'sd13848;

  // corner offsets, Q8.16 at the 24-bit delta width
  localparam logic signed [23:0] ONE_Q16    = 24'sd65536;
  localparam logic signed [23:0] G2_OFS     = 24'sd13848;
  localparam logic signed [23:0] TWO_G2_OFS = 24'sd27696;

  // falloff threshold 0.5 in Q.32
  localparam logic [31:0] HALF_Q32 = 32'h8000_0000;

  // output scale
  localparam logic signed [7:0] SCALE_70 = 8'sd70;

  // hash modulus and its reciprocal (21/256 sits just under 1/12)
  localparam logic [8:0]  HASH_MOD   = 9'd12;
  localparam logic [12:0] HASH_RECIP = 13'd21;

  // saturation bounds of the Q1.15 result
  localparam logic signed [28:0] SAT_MAX = 29'sd32767;
  localparam logic signed [28:0] SAT_MIN = -29'sd32768;

  // permutation entry modulo 12, reciprocal estimate then one correction
  function automatic logic [3:0] hash_mod12(input logic [7:0] v);
    logic [12:0] prod;
    logic [4:0]  quot;
    logic [8:0]  rem;
    prod = 13'(v) * HASH_RECIP;
    quot = prod[12:8];
    rem  = 9'(v) - 9'(quot) * HASH_MOD;
    if (rem >= HASH_MOD) begin
      rem = rem - HASH_MOD;
    end
    return rem[3:0];
  endfunction

endpackage

### src/snd_corner.sv
`timescale 1ns / 1ps
// One simplex corner: squared distance, falloff to the fourth power and gradient dot product.
// Five register stages; depends on snd_pkg.

module snd_corner (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic signed [23:0] dx_i,
  input  logic signed [23:0] dy_i,
  input  logic signed [15:0] gx_i,
  input  logic signed [15:0] gy_i,
  output logic signed [63:0] term_o
);

  // stage a: squared distance and dot product
  logic signed [47:0] sqx, sqy;
  logic signed [17:0] dxn, dyn;
  logic signed [33:0] ngx, ngy;
  logic [48:0]        r2_d, r2_q;
  logic signed [34:0] na_d, na_q;

  assign sqx  = dx_i * dx_i;
  assign sqy  = dy_i * dy_i;
  assign r2_d = {1'b0, sqx} + {1'b0, sqy};
  // inside the falloff the deltas fit 18 bits
  assign dxn  = dx_i[17:0];
  assign dyn  = dy_i[17:0];
  assign ngx  = gx_i * dxn;
  assign ngy  = gy_i * dyn;
  assign na_d = 35'(ngx) + 35'(ngy);

  // stage b: falloff 0.5 - r^2 in Q.30
  logic        inb_d, inb_q;
  logic [31:0] diff;
  logic [29:0] t1_d, t1_q;
  logic signed [34:0] nb_q;

  assign inb_d = (r2_q < 49'(snd_pkg::HALF_Q32));
  assign diff  = snd_pkg::HALF_Q32 - r2_q[31:0];
  assign t1_d  = diff[31:2];

  // stage c: first square
  logic [59:0] sq1_full;
  logic [29:0] sq1_q;
  logic        inc_q;
  logic signed [34:0] nc_q;

  assign sq1_full = t1_q * t1_q;

  // stage d: second square
  logic [59:0] sq2_full;
  logic [29:0] sq2_q;
  logic        ind_q;
  logic signed [34:0] nd_q;

  assign sq2_full = sq1_q * sq1_q;

  // stage e: weighted contribution
  logic signed [30:0] sq2_s;
  logic signed [65:0] term_full;
  logic signed [63:0] term_d, term_q;

  assign sq2_s     = $signed({1'b0, sq2_q});
  assign term_full = sq2_s * nd_q;
  assign term_d    = ind_q ? term_full[63:0] : 64'sd0;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r2_q   <= r2_d;
      na_q   <= na_d;
      inb_q  <= inb_d;
      t1_q   <= t1_d;
      nb_q   <= na_q;
      sq1_q  <= sq1_full[59:30];
      inc_q  <= inb_q;
      nc_q   <= nb_q;
      sq2_q  <= sq2_full[59:30];
      ind_q  <= inc_q;
      nd_q   <= nc_q;
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

### src/simplex_noise_2d.sv
`timescale 1ns / 1ps
// Top level of the 2-D simplex noise block: skew, cell, hashing, table stores and final sum.
// Depends on snd_pkg and snd_corner.

// Accepts one item per clock unless the pipeline holds, and presents an evaluate result in
// the last of 17 register stages; the rate is set by the fully pipelined datapath, with every
// table read served by its own port of a replicated store. Load items travel down the
// pipeline and write each store copy at the stage where that copy is read, so loads and
// evaluations take effect in arrival order. Load items and unused commands give no result.
// When a result waits on out_stall_i the whole pipeline holds, and in_stall_o follows.

module simplex_noise_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [8:0]         table_index_i,
  input  logic signed [15:0] table_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] noise_value_o
);

  // pipeline control
  logic                            adv;
  logic [snd_pkg::PIPE_DEPTH-1:0]  vld_q;
  logic [1:0]                      cmd_q [snd_pkg::PIPE_DEPTH];
  logic [8:0]                      tidx_q [snd_pkg::LOAD_DEPTH];
  logic [15:0]                     tval_q [snd_pkg::LOAD_DEPTH];

  assign out_valid_o = vld_q[snd_pkg::PIPE_DEPTH-1] &&
                       (cmd_q[snd_pkg::PIPE_DEPTH-1] == snd_pkg::CMD_EVAL);
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign adv         = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[snd_pkg::PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_q[0]  <= command_i;
      tidx_q[0] <= table_index_i;
      tval_q[0] <= table_value_i;
      for (int k = 1; k < snd_pkg::PIPE_DEPTH; k++) begin
        cmd_q[k] <= cmd_q[k-1];
      end
      for (int k = 1; k < snd_pkg::LOAD_DEPTH; k++) begin
        tidx_q[k] <= tidx_q[k-1];
        tval_q[k] <= tval_q[k-1];
      end
    end
  end

  // stage 1: coordinate sum
  logic signed [31:0] s1_x_q, s1_y_q;
  logic signed [32:0] s1_xy_d, s1_xy_q;
  assign s1_xy_d = 33'(point_x_i) + 33'(point_y_i);

  // stage 2: skew
  logic signed [49:0] skew_prod;
  logic signed [31:0] s2_x_q, s2_y_q, s2_s_q;
  assign skew_prod = s1_xy_q * snd_pkg::F2_Q16;

  // stage 3: cell index and fraction
  logic signed [32:0] xs, ys;
  logic signed [16:0] s3_ci_q, s3_cj_q;
  logic [15:0]        s3_fx_q, s3_fy_q;
  logic signed [31:0] s3_s_q;
  assign xs = 33'(s2_x_q) + 33'(s2_s_q);
  assign ys = 33'(s2_y_q) + 33'(s2_s_q);

  // stage 4: unskew and first permutation lookup
  logic signed [17:0] cisum;
  logic signed [33:0] t_prod;
  logic signed [31:0] s4_t_q, s4_s_q;
  logic [15:0]        s4_fx_q, s4_fy_q;
  logic [7:0]         s4_ii_q;
  logic [snd_pkg::PERM_AW-1:0] pa_addr0, pa_addr1;
  logic [7:0]         pa0_q, pa1_q;
  logic [7:0]         perm_a [snd_pkg::PERM_ENTRIES];
  logic               perm_a_we;
  assign cisum    = 18'(s3_ci_q) + 18'(s3_cj_q);
  assign t_prod   = cisum * snd_pkg::G2_Q16;
  assign pa_addr0 = snd_pkg::PERM_AW'(s3_cj_q[7:0]);
  assign pa_addr1 = snd_pkg::PERM_AW'(s3_cj_q[7:0]) + snd_pkg::PERM_AW'(1);
  assign perm_a_we = adv && vld_q[2] && (cmd_q[2] == snd_pkg::CMD_PERM);

  always_ff @(posedge clk_i) begin
    if (perm_a_we) begin
      perm_a[tidx_q[2]] <= tval_q[2][7:0];
    end
    if (adv) begin
      pa0_q <= perm_a[pa_addr0];
      pa1_q <= perm_a[pa_addr1];
    end
  end

  // stage 5: first corner offset
  logic signed [33:0] x0_full, y0_full;
  logic signed [23:0] s5_x0_q, s5_y0_q;
  logic [7:0]         s5_ii_q, s5_pj0_q, s5_pj1_q;
  assign x0_full = $signed({18'b0, s4_fx_q}) - 34'(s4_s_q) + 34'(s4_t_q);
  assign y0_full = $signed({18'b0, s4_fy_q}) - 34'(s4_s_q) + 34'(s4_t_q);

  // stage 6: triangle choice
  logic               s6_step_q;
  logic signed [23:0] s6_x0_q, s6_y0_q;
  logic [7:0]         s6_ii_q, s6_pj0_q, s6_pj1_q;

  // stage 7: second permutation lookup, three corners
  logic [snd_pkg::PERM_AW-1:0] pb_addr0, pb_addr1, pc_addr;
  logic [7:0]         pb0_q, pb1_q, pc_q;
  logic [7:0]         perm_b [snd_pkg::PERM_ENTRIES];
  logic [7:0]         perm_c [snd_pkg::PERM_ENTRIES];
  logic               perm_bc_we;
  logic [7:0]         pj_mid;
  logic               s7_step_q;
  logic signed [23:0] s7_x0_q, s7_y0_q;
  assign pj_mid   = s6_step_q ? s6_pj0_q : s6_pj1_q;
  assign pb_addr0 = snd_pkg::PERM_AW'(s6_ii_q) + snd_pkg::PERM_AW'(s6_pj0_q);
  assign pb_addr1 = snd_pkg::PERM_AW'(s6_ii_q) + snd_pkg::PERM_AW'(s6_step_q) +
                    snd_pkg::PERM_AW'(pj_mid);
  assign pc_addr  = snd_pkg::PERM_AW'(s6_ii_q) + snd_pkg::PERM_AW'(1) +
                    snd_pkg::PERM_AW'(s6_pj1_q);
  assign perm_bc_we = adv && vld_q[5] && (cmd_q[5] == snd_pkg::CMD_PERM);

  always_ff @(posedge clk_i) begin
    if (perm_bc_we) begin
      perm_b[tidx_q[5]] <= tval_q[5][7:0];
      perm_c[tidx_q[5]] <= tval_q[5][7:0];
    end
    if (adv) begin
      pb0_q <= perm_b[pb_addr0];
      pb1_q <= perm_b[pb_addr1];
      pc_q  <= perm_c[pc_addr];
    end
  end

  // stage 8: gradient hashes and corner deltas
  logic [3:0]         s8_h0_q, s8_h1_q, s8_h2_q;
  logic signed [23:0] x1_d, y1_d, x2_d, y2_d;
  logic signed [23:0] s8_dx_q [3];
  logic signed [23:0] s8_dy_q [3];
  assign x1_d = s7_x0_q - (s7_step_q ? snd_pkg::ONE_Q16 : 24'sd0) + snd_pkg::G2_OFS;
  assign y1_d = s7_y0_q - (s7_step_q ? 24'sd0 : snd_pkg::ONE_Q16) + snd_pkg::G2_OFS;
  assign x2_d = s7_x0_q - snd_pkg::ONE_Q16 + snd_pkg::TWO_G2_OFS;
  assign y2_d = s7_y0_q - snd_pkg::ONE_Q16 + snd_pkg::TWO_G2_OFS;

  // stage 9: gradient lookup, one store copy per corner
  logic [15:0]        grad_m0 [snd_pkg::GRAD_ENTRIES];
  logic [15:0]        grad_m1 [snd_pkg::GRAD_ENTRIES];
  logic [15:0]        grad_m2 [snd_pkg::GRAD_ENTRIES];
  logic               grad_we;
  logic [snd_pkg::GRAD_AW-1:0] gw_addr;
  logic [snd_pkg::GRAD_AW-1:0] gx_addr [3];
  logic [snd_pkg::GRAD_AW-1:0] gy_addr [3];
  logic [15:0]        gx_q [3];
  logic [15:0]        gy_q [3];
  logic signed [23:0] s9_dx_q [3];
  logic signed [23:0] s9_dy_q [3];
  assign grad_we = adv && vld_q[7] && (cmd_q[7] == snd_pkg::CMD_GRAD) &&
                   (tidx_q[7] < 9'(snd_pkg::GRAD_ENTRIES));
  assign gw_addr = tidx_q[7][snd_pkg::GRAD_AW-1:0];
  assign gx_addr[0] = snd_pkg::GRAD_AW'({s8_h0_q, 2'b00});
  assign gy_addr[0] = snd_pkg::GRAD_AW'({s8_h0_q, 2'b01});
  assign gx_addr[1] = snd_pkg::GRAD_AW'({s8_h1_q, 2'b00});
  assign gy_addr[1] = snd_pkg::GRAD_AW'({s8_h1_q, 2'b01});
  assign gx_addr[2] = snd_pkg::GRAD_AW'({s8_h2_q, 2'b00});
  assign gy_addr[2] = snd_pkg::GRAD_AW'({s8_h2_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (grad_we) begin
      grad_m0[gw_addr] <= tval_q[7];
      grad_m1[gw_addr] <= tval_q[7];
      grad_m2[gw_addr] <= tval_q[7];
    end
    if (adv) begin
      gx_q[0] <= grad_m0[gx_addr[0]];
      gy_q[0] <= grad_m0[gy_addr[0]];
      gx_q[1] <= grad_m1[gx_addr[1]];
      gy_q[1] <= grad_m1[gy_addr[1]];
      gx_q[2] <= grad_m2[gx_addr[2]];
      gy_q[2] <= grad_m2[gy_addr[2]];
    end
  end

  // stages 10 to 14: corner contributions
  logic signed [63:0] term [3];
  for (genvar c = 0; c < 3; c++) begin : g_corner
    snd_corner u_corner (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .dx_i   (s9_dx_q[c]),
      .dy_i   (s9_dy_q[c]),
      .gx_i   ($signed(gx_q[c])),
      .gy_i   ($signed(gy_q[c])),
      .term_o (term[c])
    );
  end

  // stage 15: sum of the three corners
  logic signed [65:0] sum_d, s15_sum_q;
  assign sum_d = 66'(term[0]) + 66'(term[1]) + 66'(term[2]);

  // stage 16: scale by 70
  logic signed [35:0] sum_q30;
  logic signed [43:0] scaled_d, s16_scaled_q;
  assign sum_q30  = s15_sum_q[65:30];
  assign scaled_d = sum_q30 * snd_pkg::SCALE_70;

  // stage 17: Q1.15 with saturation
  logic signed [28:0] res_full;
  logic signed [15:0] noise_d, noise_q;
  assign res_full = s16_scaled_q[43:15];
  always_comb begin
    if (res_full > snd_pkg::SAT_MAX) begin
      noise_d = 16'sd32767;
    end else if (res_full < snd_pkg::SAT_MIN) begin
      noise_d = -16'sd32768;
    end else begin
      noise_d = res_full[15:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q   <= point_x_i;
      s1_y_q   <= point_y_i;
      s1_xy_q  <= s1_xy_d;
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s1_y_q;
      s2_s_q   <= skew_prod[47:16];
      s3_ci_q  <= xs[32:16];
      s3_cj_q  <= ys[32:16];
      s3_fx_q  <= xs[15:0];
      s3_fy_q  <= ys[15:0];
      s3_s_q   <= s2_s_q;
      s4_t_q   <= t_prod[31:0];
      s4_s_q   <= s3_s_q;
      s4_fx_q  <= s3_fx_q;
      s4_fy_q  <= s3_fy_q;
      s4_ii_q  <= s3_ci_q[7:0];
      s5_x0_q  <= x0_full[23:0];
      s5_y0_q  <= y0_full[23:0];
      s5_ii_q  <= s4_ii_q;
      s5_pj0_q <= pa0_q;
      s5_pj1_q <= pa1_q;
      s6_step_q <= (s5_x0_q > s5_y0_q);
      s6_x0_q  <= s5_x0_q;
      s6_y0_q  <= s5_y0_q;
      s6_ii_q  <= s5_ii_q;
      s6_pj0_q <= s5_pj0_q;
      s6_pj1_q <= s5_pj1_q;
      s7_step_q <= s6_step_q;
      s7_x0_q  <= s6_x0_q;
      s7_y0_q  <= s6_y0_q;
      s8_h0_q  <= snd_pkg::hash_mod12(pb0_q);
      s8_h1_q  <= snd_pkg::hash_mod12(pb1_q);
      s8_h2_q  <= snd_pkg::hash_mod12(pc_q);
      s8_dx_q[0] <= s7_x0_q;
      s8_dy_q[0] <= s7_y0_q;
      s8_dx_q[1] <= x1_d;
      s8_dy_q[1] <= y1_d;
      s8_dx_q[2] <= x2_d;
      s8_dy_q[2] <= y2_d;
      for (int c = 0; c < 3; c++) begin
        s9_dx_q[c] <= s8_dx_q[c];
        s9_dy_q[c] <= s8_dy_q[c];
      end
      s15_sum_q    <= sum_d;
      s16_scaled_q <= scaled_d;
      noise_q      <= noise_d;
    end
  end

  assign noise_value_o = noise_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the 2-D simplex noise block: table fill, directed rows, then random items.
// Depends on snd_pkg and simplex_noise_2d; expected noise comes from a local predictor.

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = snd_pkg::PIPE_DEPTH + 8;
  localparam int unsigned RANDOM_ITEMS   = 90;
  // hashes stay below 12, so no gradient entry above 45 is ever read
  localparam int unsigned GRAD_USED      = 48;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  typedef struct {
    logic [1:0]         cmd;
    logic [8:0]         idx;
    logic signed [15:0] val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    bit                 typed;
    logic signed [15:0] noise;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic [8:0]         table_index;
  logic signed [15:0] table_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] noise_value;

  // local copies of the two stores
  logic [7:0]         perm_mem [snd_pkg::PERM_ENTRIES];
  logic signed [15:0] grad_mem [snd_pkg::GRAD_ENTRIES];
  logic signed [15:0] noise_expected [$];

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned quiet_cycles;
  int unsigned fails;
  dir_row_t    dir_rows [20];

  simplex_noise_2d u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .table_index_i (table_index),
    .table_value_i (table_value),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .noise_value_o (noise_value)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // gradient component as a wide signed value
  function automatic longint grad_at(int unsigned idx);
    return longint'(grad_mem[idx]);
  endfunction

  // one corner: falloff to the fourth times gradient dot product, Q.60
  function automatic longint corner_noise(longint dx, longint dy, int unsigned h);
    longint r2;
    longint fall;
    longint dot;
    r2 = dx * dx + dy * dy;
    if (r2 >= 64'sh8000_0000) begin
      return 0;
    end
    fall = (64'sh8000_0000 - r2) >>> 2;
    fall = (fall * fall) >>> 30;
    fall = (fall * fall) >>> 30;
    dot  = grad_at(h * 4) * dx + grad_at(h * 4 + 1) * dy;
    return fall * dot;
  endfunction

  // noise at a point, Q1.15 saturated
  function automatic logic signed [15:0] noise_at(logic signed [31:0] px,
                                                  logic signed [31:0] py);
    longint x, y, s, ci, cj, t, x0, y0, x1, y1, x2, y2, sum, r;
    int unsigned ii, jj, si, sj, h0, h1, h2;
    x  = longint'(px);
    y  = longint'(py);
    s  = ((x + y) * 23986) >>> 16;
    ci = (x + s) >>> 16;
    cj = (y + s) >>> 16;
    t  = (ci + cj) * 13848;
    x0 = x - ci * 65536 + t;
    y0 = y - cj * 65536 + t;
    si = (x0 > y0) ? 1 : 0;
    sj = 1 - si;
    x1 = x0 - si * 65536 + 13848;
    y1 = y0 - sj * 65536 + 13848;
    x2 = x0 - 65536 + 27696;
    y2 = y0 - 65536 + 27696;
    ii = int'(ci & 255);
    jj = int'(cj & 255);
    h0 = perm_mem[ii + perm_mem[jj]] % 12;
    h1 = perm_mem[ii + si + perm_mem[jj + sj]] % 12;
    h2 = perm_mem[ii + 1 + perm_mem[jj + 1]] % 12;
    sum = corner_noise(x0, y0, h0) + corner_noise(x1, y1, h1) + corner_noise(x2, y2, h2);
    r = ((sum >>> 30) * 70) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    return r[15:0];
  endfunction

  // drive one item, wait for acceptance, then update the local stores or queue the expected noise
  task automatic send_item(logic [1:0] cmd, logic [8:0] idx, logic signed [15:0] val,
                           logic signed [31:0] px, logic signed [31:0] py,
                           bit typed, logic signed [15:0] typed_noise);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    table_index <= idx;
    table_value <= val;
    point_x     <= px;
    point_y     <= py;
    do @(posedge clk_i); while (in_stall);
    case (cmd)
      snd_pkg::CMD_EVAL: begin
        noise_expected.push_back(typed ? typed_noise : noise_at(px, py));
      end
      snd_pkg::CMD_PERM: begin
        perm_mem[idx] = val[7:0];
      end
      snd_pkg::CMD_GRAD: begin
        if (idx < snd_pkg::GRAD_ENTRIES) begin
          grad_mem[idx] = val;
        end
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  // random item: mostly evaluations, some loads and unused commands
  task automatic send_random();
    int unsigned pick;
    logic [1:0]         cmd;
    logic signed [31:0] px;
    logic signed [31:0] py;
    pick = $urandom_range(99);
    cmd  = (pick < 75) ? snd_pkg::CMD_EVAL : (pick < 85) ? snd_pkg::CMD_PERM :
           (pick < 95) ? snd_pkg::CMD_GRAD : CMD_UNUSED;
    if ($urandom_range(1) == 0) begin
      px = $urandom;
      py = $urandom;
    end else begin
      px = int'($urandom_range(32'h6_0000)) - 32'sh3_0000;
      py = int'($urandom_range(32'h6_0000)) - 32'sh3_0000;
    end
    send_item(cmd, 9'($urandom_range(511)), 16'($urandom), px, py, 1'b0, '0);
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (noise_expected.size() == 0) begin
        $error("noise_value: expected none, actual %0d", noise_value);
        fails++;
      end else begin
        if (noise_value !== noise_expected[0]) begin
          $error("noise_value: expected %0d, actual %0d", noise_expected[0], noise_value);
          fails++;
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    command      = snd_pkg::CMD_EVAL;
    table_index  = '0;
    table_value  = '0;
    point_x      = '0;
    point_y      = '0;
    out_stall    = 1'b0;
    send_idle    = 0;
    recv_idle    = 0;
    quiet_cycles = 0;
    fails        = 0;

    // directed rows; gradients are all zero for the first four, so noise is zero
    dir_rows[0]  = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1,
                     16'sd0};
    dir_rows[1]  = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h8000_0000, 32'h8000_0000, 1'b1,
                     16'sd0};
    dir_rows[2]  = '{snd_pkg::CMD_EVAL, 9'h1ff, 16'h7fff, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
                     16'sd0};
    dir_rows[3]  = '{snd_pkg::CMD_EVAL, 9'd0, 16'h8000, 32'h0, 32'h0, 1'b1, 16'sd0};
    dir_rows[4]  = '{snd_pkg::CMD_GRAD, 9'd0, 16'h7fff, 32'h1234_5678, 32'h0, 1'b0, 16'sd0};
    dir_rows[5]  = '{snd_pkg::CMD_GRAD, 9'd1, 16'h8000, 32'h0, 32'hffff_ffff, 1'b0, 16'sd0};
    dir_rows[6]  = '{snd_pkg::CMD_GRAD, 9'd4, 16'h4000, 32'h0, 32'h0, 1'b0, 16'sd0};
    dir_rows[7]  = '{snd_pkg::CMD_GRAD, 9'd5, 16'hc000, 32'h0, 32'h0, 1'b0, 16'sd0};
    // index beyond the gradient table is dropped
    dir_rows[8]  = '{snd_pkg::CMD_GRAD, 9'd300, 16'h7fff, 32'h0, 32'h0, 1'b0, 16'sd0};
    dir_rows[9]  = '{snd_pkg::CMD_GRAD, 9'h1ff, 16'h8000, 32'h0, 32'h0, 1'b0, 16'sd0};
    // unused command changes nothing
    dir_rows[10] = '{CMD_UNUSED, 9'h1ff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 16'sd0};
    // only the low byte of a permutation value is kept
    dir_rows[11] = '{snd_pkg::CMD_PERM, 9'h1ff, 16'hff05, 32'h0, 32'h0, 1'b0, 16'sd0};
    dir_rows[12] = '{snd_pkg::CMD_PERM, 9'd0, 16'h0100, 32'h0, 32'h0, 1'b0, 16'sd0};
    dir_rows[13] = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h0, 32'h0, 1'b0, 16'sd0};
    dir_rows[14] = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h0000_8000, 32'h0000_4000, 1'b0,
                     16'sd0};
    dir_rows[15] = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h0000_3000, 32'h0000_c000, 1'b0,
                     16'sd0};
    dir_rows[16] = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'hffff_c000, 32'hffff_e000, 1'b0,
                     16'sd0};
    dir_rows[17] = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h7fff_ffff, 32'h8000_0000, 1'b0,
                     16'sd0};
    dir_rows[18] = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h00ff_0000, 32'h0000_0000, 1'b0,
                     16'sd0};
    // corner right on the falloff edge
    dir_rows[19] = '{snd_pkg::CMD_EVAL, 9'd0, 16'sd0, 32'h0000_b504, 32'h0000_0000, 1'b0,
                     16'sd0};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill every entry that an evaluation can read before any evaluation
    for (int i = 0; i < snd_pkg::PERM_ENTRIES; i++) begin
      send_item(snd_pkg::CMD_PERM, i[8:0], 16'($urandom), $urandom, $urandom, 1'b0, '0);
    end
    for (int i = 0; i < GRAD_USED; i++) begin
      send_item(snd_pkg::CMD_GRAD, i[8:0], 16'sd0, $urandom, $urandom, 1'b0, '0);
    end

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].px,
                dir_rows[i].py, dir_rows[i].typed, dir_rows[i].noise);
    end

    // random gradients, full range so the result saturates at times
    for (int i = 0; i < GRAD_USED; i++) begin
      send_item(snd_pkg::CMD_GRAD, i[8:0], 16'($urandom), $urandom, $urandom, 1'b0, '0);
    end

    // three idling phases, with the sender holding off until the pipe drains between them
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 15 : (ph == 1) ? 48 : 0;
      recv_idle = (ph == 0) ? 48 : (ph == 1) ? 15 : 0;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        send_random();
      end
      in_valid <= 1'b0;
      do @(negedge clk_i); while (noise_expected.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0 && noise_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
src/snd_pkg.sv
src/snd_corner.sv
src/simplex_noise_2d.sv
tb/tb.sv
